/* rtl/qid_pkg.sv */
package qid_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_BUSY    = 2'd0,
        STATUS_DONE    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    // Instruction kinds
    typedef enum logic [2:0] {
        KIND_SET_CAPACITY = 3'd0,
        KIND_NAME_REF     = 3'd1,
        KIND_LITERAL_NAME = 3'd2,
        KIND_DUPLICATE    = 3'd3,
        KIND_SECTION_ACK  = 3'd4,
        KIND_CANCEL_INCR  = 3'd5
    } kind_t;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_INTCONT = 2'd1,
        PH_STRHEAD = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // What the integer being decoded is for
    typedef enum logic [1:0] {
        ROLE_LAST  = 2'd0,
        ROLE_INDEX = 2'd1,
        ROLE_NAME  = 2'd2,
        ROLE_VALUE = 2'd3
    } role_t;

    localparam int ByteW   = 8;
    localparam int LenW    = 32;
    localparam int IntW    = 64;
    localparam int ShiftW  = 6;
    localparam int ChunkW  = 7;
    localparam int WideW   = IntW + ChunkW;

    localparam logic [ByteW-1:0] MASK_P5 = 8'h1f;
    localparam logic [ByteW-1:0] MASK_P6 = 8'h3f;
    localparam logic [ByteW-1:0] MASK_P7 = 8'h7f;

    localparam logic [ShiftW-1:0] SHIFT_LIMIT = 6'd63;
    localparam logic [ShiftW-1:0] SHIFT_STEP  = 6'd7;
    localparam logic [LenW-1:0]   LEN_MAX     = 32'hffff_ffff;

endpackage

/* rtl/qid_byte_if.sv */
interface qid_byte_if;
    logic                         valid;
    logic                         ready;
    logic [qid_pkg::ByteW-1:0]    data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* rtl/qid_result_if.sv */
interface qid_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [2:0]                   instruction_kind;
    logic [qid_pkg::LenW-1:0]     instruction_length;

    modport source (output valid, output status, output instruction_kind,
                    output instruction_length, input ready);
    modport sink   (input valid, input status, input instruction_kind,
                    input instruction_length, output ready);
endinterface

/* rtl/qpack_instruction_delimiter.sv */
// Channel   Dir  Payload                                          Beat
// stream    in   data_byte[7:0]                                   one stream byte
// result    out  status[1:0], instruction_kind[2:0],              one result per byte
//                instruction_length[31:0]
// cfg       in   cfg_we, cfg_wdata (stream_kind)                  write, no handshake
//
// One byte per cycle sustained while result.ready is high; a byte passes the byte register, then the result register.
// Byte register -> one pass of parse logic (71-bit add for the integer step) -> result register.
// Parse state advances only when the byte register hands its beat to the result register.
// A stalled result holds the byte register; stream.ready follows result.ready combinationally.
// rst_n clears parse state, the sticky error and stream_kind; no clearing pass.
module qpack_instruction_delimiter
(
    input  logic                clk,
    input  logic                rst_n,
    qid_byte_if.sink            stream,
    qid_result_if.source        result,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic stream_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_kind_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            stream_kind_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Byte register and result register handshake
    // ---------------------------------------------------------------
    logic                       s1_valid_reg;
    logic [qid_pkg::ByteW-1:0]  s1_byte_reg;
    logic                       out_valid_reg;
    logic                       s1_fire;
    logic                       in_fire;

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || s1_fire;
    assign in_fire      = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= stream.data_byte;
        end
    end

    // ---------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------
    qid_pkg::phase_t            phase_reg,  phase_next;
    qid_pkg::role_t             role_reg,   role_next;
    logic [qid_pkg::IntW-1:0]   acc_reg,    acc_next;
    logic [qid_pkg::ShiftW-1:0] shift_reg,  shift_next;
    logic [qid_pkg::IntW-1:0]   pay_reg,    pay_next;
    logic [qid_pkg::LenW-1:0]   count_reg,  count_next;
    qid_pkg::kind_t             kind_reg,   kind_next;
    logic                       error_reg,  error_next;

    // parse-pass temporaries
    logic                       head;       // byte opens a prefixed integer
    logic [qid_pkg::ByteW-1:0]  hmask;      // its prefix mask
    logic [qid_pkg::ByteW-1:0]  hval;
    logic                       int_end;
    logic [qid_pkg::IntW-1:0]   int_val;
    logic                       done;
    logic                       inv;
    logic [qid_pkg::WideW-1:0]  shifted;
    logic [qid_pkg::WideW-1:0]  sum;
    qid_pkg::status_t           status_next;

    always_comb
    begin
        phase_next = phase_reg;
        role_next  = role_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        pay_next   = pay_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        error_next = error_reg;
        head       = 1'b0;
        hmask      = qid_pkg::MASK_P7;
        hval       = '0;
        int_end    = 1'b0;
        int_val    = '0;
        done       = 1'b0;
        inv        = 1'b0;
        shifted    = qid_pkg::WideW'(s1_byte_reg[qid_pkg::ChunkW-1:0]) << shift_reg;
        sum        = qid_pkg::WideW'(acc_reg) + shifted;

        if (error_reg)
        begin
            // sticky: hold kind and length from the failing byte
            inv = 1'b1;
        end
        else if (phase_reg == qid_pkg::PH_IDLE)
        begin
            count_next = qid_pkg::LenW'(1);
            head       = 1'b1;
            if (!stream_kind_reg)
            begin
                if (s1_byte_reg[7:5] == 3'b001)
                begin
                    kind_next = qid_pkg::KIND_SET_CAPACITY;
                    role_next = qid_pkg::ROLE_LAST;
                    hmask     = qid_pkg::MASK_P5;
                end
                else if (s1_byte_reg[7])
                begin
                    kind_next = qid_pkg::KIND_NAME_REF;
                    role_next = qid_pkg::ROLE_INDEX;
                    hmask     = qid_pkg::MASK_P6;
                end
                else if (s1_byte_reg[6])
                begin
                    kind_next = qid_pkg::KIND_LITERAL_NAME;
                    role_next = qid_pkg::ROLE_NAME;
                    hmask     = qid_pkg::MASK_P5;
                end
                else
                begin
                    kind_next = qid_pkg::KIND_DUPLICATE;
                    role_next = qid_pkg::ROLE_LAST;
                    hmask     = qid_pkg::MASK_P5;
                end
            end
            else
            begin
                role_next = qid_pkg::ROLE_LAST;
                if (s1_byte_reg[7])
                begin
                    kind_next = qid_pkg::KIND_SECTION_ACK;
                    hmask     = qid_pkg::MASK_P7;
                end
                else
                begin
                    kind_next = qid_pkg::KIND_CANCEL_INCR;
                    hmask     = qid_pkg::MASK_P6;
                end
            end
        end
        else
        begin
            if (count_reg != qid_pkg::LEN_MAX)
            begin
                count_next = count_reg + qid_pkg::LenW'(1);
            end

            case (phase_reg)
                qid_pkg::PH_INTCONT:
                begin
                    // overflow when the shift has reached 63 or the chunk would carry past 64 bits
                    if (shift_reg >= qid_pkg::SHIFT_LIMIT
                        || (|sum[qid_pkg::WideW-1:qid_pkg::IntW]))
                    begin
                        error_next = 1'b1;
                        inv        = 1'b1;
                    end
                    else
                    begin
                        acc_next = sum[qid_pkg::IntW-1:0];
                        if (!s1_byte_reg[7])
                        begin
                            int_end = 1'b1;
                            int_val = sum[qid_pkg::IntW-1:0];
                        end
                        else
                        begin
                            shift_next = shift_reg + qid_pkg::SHIFT_STEP;
                        end
                    end
                end
                qid_pkg::PH_STRHEAD:
                begin
                    head  = 1'b1;
                    hmask = qid_pkg::MASK_P7;
                end
                qid_pkg::PH_PAYLOAD:
                begin
                    pay_next = pay_reg - qid_pkg::IntW'(1);
                    if (pay_reg == qid_pkg::IntW'(1))
                    begin
                        if (role_reg == qid_pkg::ROLE_NAME)
                        begin
                            role_next  = qid_pkg::ROLE_VALUE;
                            phase_next = qid_pkg::PH_STRHEAD;
                        end
                        else
                        begin
                            phase_next = qid_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = qid_pkg::PH_IDLE;
                end
            endcase
        end

        // leading byte of a prefixed integer
        if (head)
        begin
            hval = s1_byte_reg & hmask;
            if (hval < hmask)
            begin
                int_end = 1'b1;
                int_val = qid_pkg::IntW'(hval);
            end
            else
            begin
                acc_next   = qid_pkg::IntW'(hmask);
                shift_next = '0;
                phase_next = qid_pkg::PH_INTCONT;
            end
        end

        // integer finished: move to the next field of the instruction
        if (int_end)
        begin
            case (role_next)
                qid_pkg::ROLE_INDEX:
                begin
                    role_next  = qid_pkg::ROLE_VALUE;
                    phase_next = qid_pkg::PH_STRHEAD;
                end
                qid_pkg::ROLE_NAME:
                begin
                    if (int_val == '0)
                    begin
                        role_next  = qid_pkg::ROLE_VALUE;
                        phase_next = qid_pkg::PH_STRHEAD;
                    end
                    else
                    begin
                        pay_next   = int_val;
                        phase_next = qid_pkg::PH_PAYLOAD;
                    end
                end
                qid_pkg::ROLE_VALUE:
                begin
                    if (int_val == '0)
                    begin
                        phase_next = qid_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        pay_next   = int_val;
                        phase_next = qid_pkg::PH_PAYLOAD;
                    end
                end
                default:
                begin
                    phase_next = qid_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            endcase
        end

        if (inv)
        begin
            status_next = qid_pkg::STATUS_INVALID;
        end
        else if (done)
        begin
            status_next = qid_pkg::STATUS_DONE;
        end
        else
        begin
            status_next = qid_pkg::STATUS_BUSY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qid_pkg::PH_IDLE;
            role_reg  <= qid_pkg::ROLE_LAST;
            acc_reg   <= '0;
            shift_reg <= '0;
            pay_reg   <= '0;
            count_reg <= '0;
            kind_reg  <= qid_pkg::KIND_SET_CAPACITY;
            error_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            role_reg  <= role_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            pay_reg   <= pay_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            error_reg <= error_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    qid_pkg::status_t           res_status_reg;
    qid_pkg::kind_t             res_kind_reg;
    logic [qid_pkg::LenW-1:0]   res_len_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_status_reg <= status_next;
            res_kind_reg   <= kind_next;
            res_len_reg    <= count_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.status             = res_status_reg;
    assign result.instruction_kind   = res_kind_reg;
    assign result.instruction_length = res_len_reg;

`ifndef SYNTHESIS
    // error is sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("sticky error cleared");

    // every beat taken in the error state reports invalid
    a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && error_reg) |=> (res_status_reg == qid_pkg::STATUS_INVALID))
        else $error("beat after error not reported invalid");

    // a completed instruction leaves the parser idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && status_next == qid_pkg::STATUS_DONE)
        |=> (phase_reg == qid_pkg::PH_IDLE))
        else $error("instruction complete but parser not idle");

    // mid-instruction the length is never zero
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != qid_pkg::PH_IDLE) |-> (count_reg != '0))
        else $error("zero length inside an instruction");

    // a payload phase always has bytes left
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == qid_pkg::PH_PAYLOAD && !error_reg) |-> (pay_reg != '0))
        else $error("payload phase with nothing remaining");
`endif

endmodule
